[hw/rtl/mvsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mvsm_pkg;

    // Default sizes of the voice set and of each voice's sample memory.
    localparam int DEF_VOICE_COUNT = 8;
    localparam int DEF_MAX_FRAMES  = 1024;

    // Gain constants: 127 is unity, 64 is the center of the pan range.
    localparam logic [6:0] UNITY      = 7'd127;
    localparam logic [6:0] PAN_CENTER = 7'd64;

    // Reciprocal of 127 for magnitudes below 2^22: q = (m * RECIP_127) >> RECIP_SHIFT.
    localparam logic [22:0] RECIP_127   = 23'd4227331;
    localparam int          RECIP_SHIFT = 29;

    // Saturation limits of a 16-bit sample.
    localparam logic signed [15:0] SAT_MAX = 16'sd32767;
    localparam logic signed [15:0] SAT_MIN = -16'sd32768;

    // Register select taken from the word address of the configuration port.
    localparam logic REG_MASTER = 1'b0;
    localparam logic REG_STEREO = 1'b1;

    // Item kinds carried in tuser.
    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_START = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_VOL   = 3'd4,
        KIND_PAN   = 3'd5
    } t_kind;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CRD,
        S_CMOD,
        S_VRD,
        S_VCHK,
        S_SWAIT,
        S_SCALE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/mvsm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                                 i_clk,
    input  wire                                 i_we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                    i_wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/mvsm_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

module mvsm_scale
    import mvsm_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire signed [15:0] i_x,
    input  wire        [6:0]  i_g0,
    input  wire        [6:0]  i_g1,
    input  wire        [6:0]  i_g2,
    output logic              o_done,
    output logic signed [15:0] o_y
);

    logic               r_busy;
    logic               r_phase;
    logic [1:0]         r_step;
    logic               r_done;
    logic signed [15:0] r_x;
    logic signed [23:0] r_p;

    logic        [6:0]  gain;
    logic        [22:0] mag;
    logic        [45:0] prod;
    logic        [16:0] quo;
    logic signed [16:0] sq;

    // Gain for the current step: voice volume, master volume, then pan.
    always_comb begin
        case (r_step)
            2'd0:    gain = i_g0;
            2'd1:    gain = i_g1;
            default: gain = i_g2;
        endcase
    end

    // Divide the product by 127 on its magnitude, then restore the sign.
    always_comb begin
        mag  = r_p[23] ? 23'(-r_p) : 23'(r_p);
        prod = 46'(mag) * 46'(RECIP_127);
        quo  = 17'(prod >> RECIP_SHIFT);
        sq   = r_p[23] ? -$signed(quo) : $signed(quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_phase && r_step == 2'd2) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Alternate a multiply step and a divide step for each of the three gains.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x     <= i_x;
            r_step  <= 2'd0;
            r_phase <= 1'b0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_p     <= r_x * $signed({1'b0, gain});
                r_phase <= 1'b1;
            end else begin
                r_x     <= 16'(sq);
                r_phase <= 1'b0;
                r_step  <= r_step + 2'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_x;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("scale done without a running scale");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("scale started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("scale done held high");
`endif

endmodule

`default_nettype wire

[hw/rtl/multi_voice_sample_mixer_top.sv]
// Sample-playback mixer with VOICE_COUNT voices, each owning MAX_FRAMES stereo frames.
// Input beats (s_*): tuser holds the kind; tdata holds voice, frame address, channel,
// sample, length, loop flag and level. A write beat stores one sample.
// Start, stop, volume and pan beats read, modify and write the voice record.
// A tick beat sweeps the voices in order and yields one output beat (m_*) carrying
// the left and right sums and the count of voices still active.
// Per voice a tick reads and checks the voice record; a playing voice then passes
// each channel through the shared scale unit (three multiply and divide-by-127
// steps), both channels in stereo and only the left in mono. A silent or retiring
// voice skips the scale unit. After the last voice the output register is loaded,
// and the input side is ready again in the cycle after that.
// The input side is ready only when the sequencer is idle. The result sits in an
// output register, so the next beat is taken while it waits; a second tick waits at
// its end until the receiver has taken the earlier result.
// Reset (synchronous, active low) clears the voice records through per-voice valid
// bits, sets master volume to 127 and stereo mode on. The sample memory is not
// cleared and must be written before it is played.
// The APB port holds master volume at address 0 and stereo mode at address 4; it
// never waits. The user must write only while no item is in flight; it is unchecked.
`timescale 1ns / 1ps
`default_nettype none

module multi_voice_sample_mixer_top
    import mvsm_pkg::*;
#(
    parameter int VOICE_COUNT = DEF_VOICE_COUNT,
    parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // voice[2:0], frame_addr[12:3], channel_sel[13], sample_value[29:14],
    // length[40:30], loop_enable[41], level[48:42], zero fill
    input  wire  [55:0] s_tdata,
    // kind[2:0]
    input  wire  [2:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // left_sample[15:0], right_sample[31:16], active_count[35:32], zero fill
    output logic [39:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int FW    = $clog2(MAX_FRAMES);
    localparam int PW    = $clog2(MAX_FRAMES + 1);
    localparam int CW    = $clog2(VOICE_COUNT + 1);
    localparam int SAW   = VW + FW + 1;
    localparam int SDEPTH = 1 << SAW;
    localparam int VREC  = 2 * PW + 16;
    // Voice record layout.
    localparam int O_LEN = PW;
    localparam int O_VOL = 2 * PW;
    localparam int O_PAN = 2 * PW + 7;
    localparam int O_LP  = 2 * PW + 14;
    localparam int O_ACT = 2 * PW + 15;
    localparam logic [VREC-1:0] RESET_REC =
        {1'b0, 1'b0, PAN_CENTER, UNITY, {PW{1'b0}}, {PW{1'b0}}};

    // Input fields.
    t_kind              in_kind;
    logic [2:0]         in_voice;
    logic [9:0]         in_addr;
    logic               in_ch;
    logic [15:0]        in_sample;
    logic [10:0]        in_len;
    logic               in_loop;
    logic [6:0]         in_level;
    logic               accept;
    logic               voice_ok;
    logic               addr_ok;

    assign in_kind   = t_kind'(s_tuser);
    assign in_voice  = s_tdata[2:0];
    assign in_addr   = s_tdata[12:3];
    assign in_ch     = s_tdata[13];
    assign in_sample = s_tdata[29:14];
    assign in_len    = s_tdata[40:30];
    assign in_loop   = s_tdata[41];
    assign in_level  = s_tdata[48:42];
    assign voice_ok  = {29'd0, in_voice} < VOICE_COUNT;
    assign addr_ok   = {22'd0, in_addr} < MAX_FRAMES;

    // Control registers.
    t_state                 r_state, n_state;
    logic [VOICE_COUNT-1:0] r_vvalid, n_vvalid;
    logic                   r_out_valid, n_out_valid;
    logic [6:0]             r_master;
    logic                   r_stereo;

    // Working registers.
    logic [VW-1:0]      r_voice, n_voice;
    t_kind              r_kind, n_kind;
    logic [PW-1:0]      r_len, n_len;
    logic               r_loop, n_loop;
    logic [6:0]         r_level, n_level;
    logic               r_rd_valid;
    logic [VREC-1:0]    r_rec, n_rec;
    logic [6:0]         r_gl, n_gl;
    logic [6:0]         r_gr, n_gr;
    logic               r_ch, n_ch;
    logic signed [15:0] r_acc_l, n_acc_l;
    logic signed [15:0] r_acc_r, n_acc_r;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic signed [15:0] r_out_left, n_out_left;
    logic signed [15:0] r_out_right, n_out_right;
    logic [3:0]         r_out_count, n_out_count;

    // Memory ports and scale unit.
    logic               vram_we;
    logic [VREC-1:0]    vram_wdata;
    logic [VREC-1:0]    vram_rdata;
    logic               store_we;
    logic [SAW-1:0]     store_waddr;
    logic [SAW-1:0]     store_raddr;
    logic [15:0]        store_rdata;
    logic               scale_start;
    logic               scale_done;
    logic signed [15:0] scale_y;
    logic [6:0]         scale_g2;

    // Comb temporaries.
    logic [VREC-1:0]    rec;
    logic [PW-1:0]      pos;
    logic [PW-1:0]      len;
    logic [PW-1:0]      np;
    logic [7:0]         gl8;
    logic [7:0]         gr8;
    logic signed [16:0] sum;
    logic signed [15:0] sat;
    logic               fin;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);

    // Sample writes go straight to the store on the accepting edge.
    assign store_we    = accept && in_kind == KIND_WRITE && voice_ok && addr_ok;
    assign store_waddr = {VW'(in_voice), FW'(in_addr), in_ch};

    // Configuration port.
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_MASTER: prdata = {25'd0, r_master};
            default:    prdata = {31'd0, r_stereo};
        endcase
    end

    assign scale_g2 = r_ch ? r_gr : r_gl;

    // Sequencer: next state and working values.
    always_comb begin
        n_state     = r_state;
        n_vvalid    = r_vvalid;
        n_out_valid = r_out_valid;
        n_voice     = r_voice;
        n_kind      = r_kind;
        n_len       = r_len;
        n_loop      = r_loop;
        n_level     = r_level;
        n_rec       = r_rec;
        n_gl        = r_gl;
        n_gr        = r_gr;
        n_ch        = r_ch;
        n_acc_l     = r_acc_l;
        n_acc_r     = r_acc_r;
        n_cnt       = r_cnt;
        n_out_left  = r_out_left;
        n_out_right = r_out_right;
        n_out_count = r_out_count;
        vram_we     = 1'b0;
        vram_wdata  = r_rec;
        scale_start = 1'b0;
        store_raddr = {r_voice, FW'(r_rec[PW-1:0]), 1'b1};
        rec         = r_rd_valid ? vram_rdata : RESET_REC;
        pos         = rec[PW-1:0];
        len         = rec[O_LEN +: PW];
        np          = r_rec[PW-1:0] + PW'(1);
        gl8         = {UNITY - rec[O_PAN +: 7], 1'b0};
        gr8         = {rec[O_PAN +: 7], 1'b0};
        sum         = 17'(scale_y) + (r_ch ? 17'(r_acc_r) : 17'(r_acc_l));
        sat         = (sum > 17'(SAT_MAX)) ? SAT_MAX :
                      (sum < 17'(SAT_MIN)) ? SAT_MIN : 16'(sum);
        fin         = 1'b0;

        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_voice = VW'(in_voice);
                    n_kind  = in_kind;
                    n_len   = ({21'd0, in_len} > MAX_FRAMES) ? PW'(MAX_FRAMES)
                                                            : PW'(in_len);
                    n_loop  = in_loop;
                    n_level = in_level;
                    case (in_kind)
                        KIND_TICK: begin
                            n_voice = '0;
                            n_acc_l = '0;
                            n_acc_r = '0;
                            n_cnt   = '0;
                            n_state = S_VRD;
                        end
                        KIND_START: begin
                            if (voice_ok && in_len != 11'd0) n_state = S_CRD;
                        end
                        KIND_STOP, KIND_VOL, KIND_PAN: begin
                            if (voice_ok) n_state = S_CRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_CRD: n_state = S_CMOD;
            S_CMOD: begin
                // Update one field group of the voice record and write it back.
                vram_wdata = rec;
                case (r_kind)
                    KIND_START: begin
                        vram_wdata[PW-1:0]     = '0;
                        vram_wdata[O_LEN +: PW] = r_len;
                        vram_wdata[O_LP]       = r_loop;
                        vram_wdata[O_ACT]      = 1'b1;
                    end
                    KIND_STOP: begin
                        vram_wdata[PW-1:0] = '0;
                        vram_wdata[O_ACT]  = 1'b0;
                    end
                    KIND_VOL: vram_wdata[O_VOL +: 7] = r_level;
                    default:  vram_wdata[O_PAN +: 7] = r_level;
                endcase
                vram_we           = 1'b1;
                n_vvalid[r_voice] = 1'b1;
                n_state           = S_IDLE;
            end
            S_VRD: n_state = S_VCHK;
            S_VCHK: begin
                if (!rec[O_ACT] || len == '0) begin
                    n_cnt = r_cnt + CW'(rec[O_ACT]);
                    fin   = 1'b1;
                end else if (pos >= len && !rec[O_LP]) begin
                    vram_wdata        = rec;
                    vram_wdata[O_ACT] = 1'b0;
                    vram_we           = 1'b1;
                    n_vvalid[r_voice] = 1'b1;
                    fin               = 1'b1;
                end else begin
                    if (pos >= len) pos = '0;
                    n_rec          = rec;
                    n_rec[PW-1:0]  = pos;
                    n_gl           = r_stereo ? ((gl8 > 8'd127) ? UNITY : gl8[6:0]) : UNITY;
                    n_gr           = r_stereo ? ((gr8 > 8'd127) ? UNITY : gr8[6:0]) : UNITY;
                    n_ch           = 1'b0;
                    store_raddr    = {r_voice, FW'(pos), 1'b0};
                    n_state        = S_SWAIT;
                end
            end
            S_SWAIT: begin
                scale_start = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                if (scale_done) begin
                    if (!r_ch) begin
                        n_acc_l = sat;
                    end else begin
                        n_acc_r = sat;
                    end
                    if (!r_ch && r_stereo) begin
                        n_ch    = 1'b1;
                        n_state = S_SWAIT;
                    end else begin
                        // Advance the position; wrap or retire at the end.
                        vram_wdata = r_rec;
                        if (np >= r_rec[O_LEN +: PW]) begin
                            vram_wdata[PW-1:0] = '0;
                            if (!r_rec[O_LP]) vram_wdata[O_ACT] = 1'b0;
                        end else begin
                            vram_wdata[PW-1:0] = np;
                        end
                        vram_we           = 1'b1;
                        n_vvalid[r_voice] = 1'b1;
                        n_cnt             = r_cnt + CW'(vram_wdata[O_ACT]);
                        fin               = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_tready) begin
                    n_out_left  = r_acc_l;
                    n_out_right = r_stereo ? r_acc_r : 16'sd0;
                    n_out_count = 4'(r_cnt);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Move on to the next voice or close the frame.
        if (fin) begin
            if (r_voice == VW'(VOICE_COUNT - 1)) begin
                n_state = S_OUT;
            end else begin
                n_voice = r_voice + VW'(1);
                n_state = S_VRD;
            end
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vvalid    <= '0;
            r_out_valid <= 1'b0;
            r_master    <= UNITY;
            r_stereo    <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_vvalid    <= n_vvalid;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_MASTER: r_master <= pwdata[6:0];
                    default:    r_stereo <= pwdata[0];
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_voice     <= n_voice;
        r_kind      <= n_kind;
        r_len       <= n_len;
        r_loop      <= n_loop;
        r_level     <= n_level;
        r_rd_valid  <= r_vvalid[r_voice];
        r_rec       <= n_rec;
        r_gl        <= n_gl;
        r_gr        <= n_gr;
        r_ch        <= n_ch;
        r_acc_l     <= n_acc_l;
        r_acc_r     <= n_acc_r;
        r_cnt       <= n_cnt;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
        r_out_count <= n_out_count;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out_count, r_out_right, r_out_left};

    // Voice records.
    mvsm_ram #(
        .WIDTH (VREC),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (r_voice),
        .i_wdata (vram_wdata),
        .i_raddr (r_voice),
        .o_rdata (vram_rdata)
    );

    // Sample store, one entry per voice, frame and channel.
    mvsm_ram #(
        .WIDTH (16),
        .DEPTH (SDEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (in_sample),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    mvsm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scale_start),
        .i_x     ($signed(store_rdata)),
        .i_g0    (r_rec[O_VOL +: 7]),
        .i_g1    (r_master),
        .i_g2    (scale_g2),
        .o_done  (scale_done),
        .o_y     (scale_y)
    );

`ifndef ASSERT_OFF
    a_out_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside the end of a tick");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> {28'd0, r_out_count} <= VOICE_COUNT)
        else $error("active count above voice count");
    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_we |-> r_state == S_IDLE)
        else $error("sample write during a sweep");
    a_mono_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !r_stereo) |-> r_out_right == 16'sd0)
        else $error("right sample nonzero in mono mode");
`endif

endmodule

`default_nettype wire

[bench/tb_multi_voice_sample_mixer_top.sv]
`timescale 1ns / 1ps

module tb_multi_voice_sample_mixer_top
    import mvsm_pkg::*;
();

    localparam int VOICES     = 8;
    localparam int FRAMES     = 1024;
    localparam int STORE_SIZE = VOICES * FRAMES * 2;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    // One input beat, fields as carried on the stream.
    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         voice;
        logic [9:0]         frame_addr;
        logic               channel_sel;
        logic signed [15:0] sample_value;
        logic [10:0]        length;
        logic               loop_enable;
        logic [6:0]         level;
    } t_mix_cmd;

    // One mixed output frame.
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [3:0]         active_count;
    } t_mix_frame;

    typedef struct packed {
        logic [10:0] pos;
        logic [10:0] len;
        logic [6:0]  vol;
        logic [6:0]  pan;
        logic        loop_on;
        logic        active;
    } t_voice_rec;

    typedef struct packed {
        t_voice_rec [VOICES-1:0] vc;
        logic [6:0]              master;
        logic                    stereo;
    } t_mixer_state;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multi_voice_sample_mixer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sample memory as the block holds it, and which entries the stimulus has filled.
    bit signed [15:0] pcm_store [0:STORE_SIZE-1];
    bit               pcm_filled [0:STORE_SIZE-1];

    t_mix_cmd     cmd_feed[$];
    t_mix_frame   frames_due[$];
    t_mixer_state plan_st;
    t_mixer_state dut_st;
    t_mix_cmd     cur_cmd;
    bit           calm;
    int           send_gap;
    int           recv_gap;
    int           mismatches;
    int           frames_checked;
    int           beats_sent;
    int           beats_planned;
    int           idle_cycles;

    function automatic int store_idx(input int v, input int f, input int c);
        return (v * FRAMES + f) * 2 + c;
    endfunction

    function automatic int gain_div(input int s, input int g);
        return (s * g) / 127;
    endfunction

    function automatic int clip16(input int x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // Apply one beat to a mixer state; a tick also yields the mixed frame.
    // Sample writes land in the store only when commit is set.
    function automatic void mixer_apply(input t_mixer_state st_in, input t_mix_cmd cmd,
                                        input bit commit, output t_mixer_state st,
                                        output bit has_frame, output t_mix_frame fr);
        int acc [2];
        int gain [2];
        int s;
        int nch;
        int cnt;
        int p;
        st = st_in;
        has_frame = 1'b0;
        fr = '0;
        if (cmd.kind == KIND_TICK) begin
            acc[0] = 0;
            acc[1] = 0;
            nch = st.stereo ? 2 : 1;
            for (int v = 0; v < VOICES; v++) begin
                if (!st.vc[v].active || st.vc[v].len == 0) continue;
                gain[0] = 127;
                gain[1] = 127;
                if (st.stereo) begin
                    p = st.vc[v].pan;
                    gain[0] = ((127 - p) * 2 > 127) ? 127 : (127 - p) * 2;
                    gain[1] = (p * 2 > 127) ? 127 : p * 2;
                end
                if (st.vc[v].pos >= st.vc[v].len) begin
                    if (st.vc[v].loop_on) begin
                        st.vc[v].pos = '0;
                    end else begin
                        st.vc[v].active = 1'b0;
                        continue;
                    end
                end
                for (int c = 0; c < nch; c++) begin
                    s = pcm_store[store_idx(v, st.vc[v].pos, c)];
                    s = gain_div(s, st.vc[v].vol);
                    s = gain_div(s, st.master);
                    s = gain_div(s, gain[c]);
                    acc[c] = clip16(acc[c] + s);
                end
                st.vc[v].pos = st.vc[v].pos + 11'd1;
                if (st.vc[v].pos >= st.vc[v].len) begin
                    if (st.vc[v].loop_on) st.vc[v].pos = '0;
                    else st.vc[v].active = 1'b0;
                end
            end
            cnt = 0;
            for (int v = 0; v < VOICES; v++) if (st.vc[v].active) cnt++;
            has_frame = 1'b1;
            fr.left = acc[0][15:0];
            fr.right = st.stereo ? acc[1][15:0] : 16'sd0;
            fr.active_count = cnt[3:0];
        end else begin
            case (cmd.kind)
                KIND_WRITE: begin
                    if (commit)
                        pcm_store[store_idx(cmd.voice, cmd.frame_addr, cmd.channel_sel)]
                            = cmd.sample_value;
                end
                KIND_START: begin
                    if (cmd.length != 0) begin
                        st.vc[cmd.voice].len = (cmd.length > FRAMES) ? 11'(FRAMES) : cmd.length;
                        st.vc[cmd.voice].pos = '0;
                        st.vc[cmd.voice].loop_on = cmd.loop_enable;
                        st.vc[cmd.voice].active = 1'b1;
                    end
                end
                KIND_STOP: begin
                    st.vc[cmd.voice].active = 1'b0;
                    st.vc[cmd.voice].pos = '0;
                end
                KIND_VOL: st.vc[cmd.voice].vol = cmd.level;
                KIND_PAN: st.vc[cmd.voice].pan = cmd.level;
                default: ;
            endcase
        end
    endfunction

    function automatic t_mixer_state reset_state();
        t_mixer_state st;
        st = '0;
        for (int v = 0; v < VOICES; v++) begin
            st.vc[v].vol = UNITY;
            st.vc[v].pan = PAN_CENTER;
        end
        st.master = UNITY;
        st.stereo = 1'b1;
        return st;
    endfunction

    function automatic t_mix_cmd rand_cmd(input logic [2:0] kind);
        t_mix_cmd    c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(t_mix_cmd)-1:0];
        c.kind = kind;
        return c;
    endfunction

    // Queue a beat and advance the planning copy of the mixer.
    task automatic queue_cmd(input t_mix_cmd c);
        t_mixer_state nx;
        bit hf;
        t_mix_frame fr;
        if (c.kind == KIND_WRITE)
            pcm_filled[store_idx(c.voice, c.frame_addr, c.channel_sel)] = 1'b1;
        mixer_apply(plan_st, c, 1'b0, nx, hf, fr);
        plan_st = nx;
        cmd_feed = {cmd_feed, c};
        beats_planned++;
    endtask

    // Before a tick, fill any sample the active voices are about to play.
    task automatic queue_tick();
        t_mix_cmd c;
        int p;
        for (int v = 0; v < VOICES; v++) begin
            if (!plan_st.vc[v].active || plan_st.vc[v].len == 0) continue;
            p = plan_st.vc[v].pos;
            if (p >= plan_st.vc[v].len) begin
                if (!plan_st.vc[v].loop_on) continue;
                p = 0;
            end
            for (int ch = 0; ch < (plan_st.stereo ? 2 : 1); ch++) begin
                if (!pcm_filled[store_idx(v, p, ch)]) begin
                    c = rand_cmd(KIND_WRITE);
                    c.voice = 3'(v);
                    c.frame_addr = 10'(p);
                    c.channel_sel = ch[0];
                    queue_cmd(c);
                end
            end
        end
        queue_cmd(rand_cmd(KIND_TICK));
    endtask

    task automatic queue_op(input logic [2:0] kind, input int v, input int val,
                            input bit lp);
        t_mix_cmd c;
        c = rand_cmd(kind);
        c.voice = 3'(v);
        c.loop_enable = lp;
        if (kind == KIND_START) c.length = 11'(val);
        if (kind == KIND_VOL || kind == KIND_PAN) c.level = 7'(val);
        if (kind == KIND_WRITE) begin
            c.frame_addr = 10'(val);
            c.sample_value = lp ? 16'sh7fff : 16'sh8000;
            c.channel_sel = val[0];
        end
        queue_cmd(c);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until the block has nothing queued or owed, then let it settle.
    task automatic drain();
        do @(negedge i_clk);
        while (cmd_feed.size() != 0 || s_tvalid || frames_due.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_mode(input int master, input bit stereo);
        apb_write(REG_MASTER, 32'(master));
        apb_write(REG_STEREO, {31'd0, stereo});
        plan_st.master = 7'(master);
        plan_st.stereo = stereo;
        dut_st.master = 7'(master);
        dut_st.stereo = stereo;
    endtask

    // Queue about n beats, sample fills for ticks included.
    task automatic random_phase(input int n);
        int r;
        int stop_at;
        t_mix_cmd c;
        @(negedge i_clk);
        stop_at = beats_planned + n;
        while (beats_planned < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                queue_tick();
            end else if (r < 58) begin
                c = rand_cmd(KIND_WRITE);
                if ($urandom_range(0, 3) != 0) c.frame_addr = 10'($urandom_range(0, 31));
                queue_cmd(c);
            end else if (r < 72) begin
                c = rand_cmd(KIND_START);
                if ($urandom_range(0, 5) != 0) c.length = 11'($urandom_range(1, 16));
                queue_cmd(c);
            end else if (r < 78) begin
                queue_cmd(rand_cmd(KIND_STOP));
            end else if (r < 87) begin
                queue_cmd(rand_cmd(KIND_VOL));
            end else if (r < 96) begin
                queue_cmd(rand_cmd(KIND_PAN));
            end else begin
                queue_cmd(rand_cmd($urandom_range(0, 1) ? KIND_RSVD6 : KIND_RSVD7));
            end
        end
    endtask

    // Stimulus: directed beats first, then random phases under several modes.
    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        beats_planned = 0;
        plan_st = reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(127, 1'b1);
        @(negedge i_clk);

        // Full-scale samples, hard pans, both voice volume extremes.
        queue_op(KIND_WRITE, 0, 0, 1'b1);
        queue_op(KIND_WRITE, 0, 1, 1'b0);
        queue_op(KIND_WRITE, 7, 1023, 1'b1);
        queue_op(KIND_START, 0, 1, 1'b1);
        queue_op(KIND_PAN, 0, 0, 1'b0);
        queue_tick();
        queue_op(KIND_PAN, 0, 127, 1'b0);
        queue_tick();
        queue_op(KIND_START, 1, 2047, 1'b0);
        queue_op(KIND_VOL, 1, 0, 1'b0);
        queue_tick();
        queue_op(KIND_STOP, 1, 0, 1'b0);
        queue_op(KIND_START, 2, 0, 1'b1);
        queue_op(KIND_START, 3, 1024, 1'b0);
        queue_op(KIND_START, 4, 2, 1'b0);
        queue_op(KIND_VOL, 4, 127, 1'b0);
        queue_tick();
        queue_tick();
        queue_tick();
        queue_cmd(rand_cmd(KIND_RSVD6));
        queue_cmd(rand_cmd(KIND_RSVD7));
        queue_op(KIND_STOP, 3, 0, 1'b0);
        queue_tick();
        drain();

        set_mode(0, 1'b1);
        random_phase(250);
        drain();
        set_mode(127, 1'b0);
        calm = 1'b1;
        random_phase(250);
        drain();
        calm = 1'b0;
        set_mode(1, 1'b0);
        random_phase(250);
        drain();
        set_mode(64, 1'b1);
        random_phase(250);
        drain();
        set_mode(100, 1'b1);
        random_phase(250);
        drain();
        repeat (200) @(negedge i_clk);

        $display("Covered %0d beats and %0d checked frames across six mode settings,",
                 beats_sent, frames_checked);
        $display("including mono and stereo, master gain extremes and voice restarts.");
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Driver: present queued beats with random gaps; predict on each accepted beat.
    always @(posedge i_clk) begin
        t_mixer_state nx;
        bit hf;
        t_mix_frame fr;
        int gap;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
            dut_st   <= reset_state();
            beats_sent <= 0;
        end else if (s_tvalid && s_tready) begin
            mixer_apply(dut_st, cur_cmd, 1'b1, nx, hf, fr);
            dut_st <= nx;
            if (hf) frames_due = {frames_due, fr};
            beats_sent <= beats_sent + 1;
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap == 0 && cmd_feed.size() != 0) begin
                cur_cmd = cmd_feed.pop_front();
                s_tdata <= {7'd0, cur_cmd.level, cur_cmd.loop_enable, cur_cmd.length,
                            cur_cmd.sample_value, cur_cmd.channel_sel,
                            cur_cmd.frame_addr, cur_cmd.voice};
                s_tuser <= cur_cmd.kind;
            end else begin
                s_tvalid <= 1'b0;
                send_gap <= gap;
            end
        end else if (!s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (cmd_feed.size() != 0) begin
                cur_cmd = cmd_feed.pop_front();
                s_tdata <= {7'd0, cur_cmd.level, cur_cmd.loop_enable, cur_cmd.length,
                            cur_cmd.sample_value, cur_cmd.channel_sel,
                            cur_cmd.frame_addr, cur_cmd.voice};
                s_tuser  <= cur_cmd.kind;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Monitor: stall the result side at random and check each frame in order.
    always @(posedge i_clk) begin
        t_mix_frame want;
        t_mix_frame got;
        int gap;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            mismatches <= 0;
            frames_checked <= 0;
        end else if (m_tvalid && m_tready) begin
            got.left = m_tdata[15:0];
            got.right = m_tdata[31:16];
            got.active_count = m_tdata[35:32];
            if (frames_due.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected frame L=%0d R=%0d n=%0d", $realtime,
                             got.left, got.right, got.active_count);
                mismatches <= mismatches + 1;
            end else begin
                want = frames_due.pop_front();
                if (want != got) begin
                    if (mismatches < 10)
                        $display("%0t: frame %0d exp L=%0d R=%0d n=%0d got L=%0d R=%0d n=%0d",
                                 $realtime, frames_checked, want.left, want.right,
                                 want.active_count, got.left, got.right, got.active_count);
                    mismatches <= mismatches + 1;
                end
                frames_checked <= frames_checked + 1;
            end
            gap = calm ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
                m_tready <= 1'b0;
                recv_gap <= gap - 1;
            end
        end else if (!m_tready) begin
            if (recv_gap > 0) recv_gap <= recv_gap - 1;
            else m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
